>>> rtl/jsu_pkg.sv
// package: payload types, character codes and utf-8 constants for the json string unescape unit
`timescale 1ns / 1ps

package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
  } out_req_t;

  // decoded bytes caused by one input request
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            marker;
    logic            eos;
  } grp_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_FF  = 8'h0C;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_CR  = 8'h0D;
  localparam logic [7:0] CC_TAB = 8'h09;

  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [7:0]  UTF8_MASK  = 8'h3F;
  localparam logic [15:0] CP_ONE_MAX = 16'h0080;
  localparam logic [15:0] CP_TWO_MAX = 16'h0800;

endpackage

>>> rtl/jsu_decode.sv
// decoder: escape state and per-request byte group generation
`timescale 1ns / 1ps

module jsu_decode import jsu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  in_req_t in_data,
  output grp_t    grp
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_HALTED = 2'd3
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] acc_r, acc_nxt;

  logic [7:0]  c;
  logic [3:0]  nib;
  logic        hex_ok;
  logic [15:0] cp;

  assign c  = in_data.in_byte;
  assign cp = {acc_r[11:0], nib};

  always_comb begin
    hex_ok = 1'b1;
    nib    = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      nib = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      nib = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    grp         = '0;
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    acc_nxt     = acc_r;
    case (mode_r)
      MODE_NORMAL: begin
        if (c == CH_BSLASH) begin
          mode_nxt = MODE_ESCAPE;
        end else begin
          grp.bytes[0] = c;
          grp.cnt      = 2'd1;
        end
      end
      MODE_ESCAPE: begin
        if (c == CH_U) begin
          mode_nxt    = MODE_HEX;
          hex_cnt_nxt = 2'd0;
          acc_nxt     = 16'd0;
        end else begin
          mode_nxt = MODE_NORMAL;
          grp.cnt  = 2'd1;
          case (c)
            CH_QUOTE:  grp.bytes[0] = CH_QUOTE;
            CH_BSLASH: grp.bytes[0] = CH_BSLASH;
            CH_SLASH:  grp.bytes[0] = CH_SLASH;
            CH_B:      grp.bytes[0] = CC_BS;
            CH_F:      grp.bytes[0] = CC_FF;
            CH_N:      grp.bytes[0] = CC_LF;
            CH_R:      grp.bytes[0] = CC_CR;
            CH_T:      grp.bytes[0] = CC_TAB;
            default: begin
              grp.bytes[0] = CH_BSLASH;
              grp.bytes[1] = c;
              grp.cnt      = 2'd2;
            end
          endcase
        end
      end
      MODE_HEX: begin
        if (!hex_ok) begin
          mode_nxt = MODE_HALTED;
        end else if (hex_cnt_r == 2'd3) begin
          if (cp < CP_ONE_MAX) begin
            grp.bytes[0] = cp[7:0];
            grp.cnt      = 2'd1;
          end else if (cp < CP_TWO_MAX) begin
            grp.bytes[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
            grp.bytes[1] = UTF8_CONT | ({2'd0, cp[5:0]} & UTF8_MASK);
            grp.cnt      = 2'd2;
          end else begin
            grp.bytes[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
            grp.bytes[1] = UTF8_CONT | ({2'd0, cp[11:6]} & UTF8_MASK);
            grp.bytes[2] = UTF8_CONT | ({2'd0, cp[5:0]} & UTF8_MASK);
            grp.cnt      = 2'd3;
          end
          mode_nxt    = MODE_NORMAL;
          hex_cnt_nxt = 2'd0;
          acc_nxt     = 16'd0;
        end else begin
          acc_nxt     = cp;
          hex_cnt_nxt = hex_cnt_r + 2'd1;
        end
      end
      MODE_HALTED: begin
        mode_nxt = MODE_HALTED;
      end
      default: begin
        mode_nxt = MODE_NORMAL;
      end
    endcase

    if (in_data.is_final) begin
      if (grp.cnt == 2'd0) begin
        grp.cnt    = 2'd1;
        grp.marker = 1'b1;
      end
      grp.eos     = 1'b1;
      mode_nxt    = MODE_NORMAL;
      hex_cnt_nxt = 2'd0;
      acc_nxt     = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      hex_cnt_r <= 2'd0;
      acc_r     <= 16'd0;
    end else if (in_fire) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

>>> rtl/jsu_emit.sv
// result register: holds one byte group and sends it out one byte per request
`timescale 1ns / 1ps

module jsu_emit import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  grp_t     grp,
  output logic     can_load,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  grp_t       grp_r;
  logic       full_r, full_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       at_last;
  logic       out_fire;

  assign at_last   = (idx_r == grp_r.cnt - 2'd1);
  assign out_fire  = out_valid && out_ready;
  assign out_valid = full_r;
  assign can_load  = !full_r || (out_ready && at_last);

  always_comb begin
    case (idx_r)
      2'd0:    out_data.out_byte = grp_r.bytes[0];
      2'd1:    out_data.out_byte = grp_r.bytes[1];
      2'd2:    out_data.out_byte = grp_r.bytes[2];
      default: out_data.out_byte = 8'd0;
    endcase
    out_data.byte_valid    = !grp_r.marker;
    out_data.end_of_string = grp_r.eos && at_last;
  end

  always_comb begin
    full_nxt = full_r;
    idx_nxt  = idx_r;
    if (out_fire) begin
      if (at_last) begin
        full_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (load) begin
      full_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      full_r <= full_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
  end

endmodule

>>> rtl/json_string_unescape_unit.sv
// top level: json string interior unescape with utf-8 output of \u escapes
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_ready   in_req_t  (in_byte, is_final)
//   out_     out  out_valid / out_ready out_req_t (out_byte, byte_valid, end_of_string)
//
// a request is decoded in the cycle it is accepted and its bytes land in the result register
// one request per cycle while each yields at most one byte and out_ready is high; a request that
// yields several bytes holds the input until its last byte is sent on the single-byte output port
// out_ready low with a byte group pending holds in_ready low
// synchronous reset returns the escape state to plain text and empties the result register
`timescale 1ns / 1ps

module json_string_unescape_unit import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  grp_t grp;
  logic in_fire;
  logic can_load;

  assign in_ready = can_load;
  assign in_fire  = in_valid && in_ready;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .grp     (grp)
  );

  jsu_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && (grp.cnt != 2'd0)),
    .grp       (grp),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/jsu_checker.sv
// checker: port-level properties of the unescape unit, bound to the top level
`timescale 1ns / 1ps

module jsu_checker import jsu_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_req_t out_data
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a marker with no byte is only the end of a string
  a_marker_eos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.end_of_string)
    else $error("empty marker without end of string");

  // a marker carries a zero byte
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'd0)
    else $error("marker with nonzero byte");

  // a stalled result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
